### src/signed_radix_digit_emitter_unit_defines.svh
// ---------------------------------------------------------------------------
// signed radix digit emitter assertion macros
// shared property shapes for the port checker
// ---------------------------------------------------------------------------
`ifndef SIGNED_RADIX_DIGIT_EMITTER_UNIT_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SRE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SRE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sre_pkg.sv
// ---------------------------------------------------------------------------
// sre_pkg
// types, constants and register indexes of the signed radix digit emitter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sre_pkg;

  localparam int DEF_MAX_RADIX  = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int SYM_COUNT   = 16;
  localparam int SYM_IDX_W   = 4;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  localparam logic [CFG_INDEX_W-1:0] REG_RADIX_SIZE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic conv_last;
    logic digit_last;
  } status_t;

endpackage

### src/sre_ctrl.sv
// ---------------------------------------------------------------------------
// sre_ctrl
// sequencer: load, bit-serial conversion, sign word, digit words
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sre_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  sre_pkg::status_t status,
  output sre_pkg::cmd_t    cmd,
  output logic            busy
);
  import sre_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        // a bad alphabet swallows the word with no output
        if (start && status.alpha_ok) state_next = S_CONV;
      end
      S_CONV: begin
        if (status.conv_last) state_next = status.neg ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.digit_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start && status.alpha_ok;
      end
      S_CONV: begin
        cmd.shift = 1'b1;
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### src/sre_datapath.sv
// ---------------------------------------------------------------------------
// sre_datapath
// config registers, alphabet check, radix digit accumulator, output word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sre_datapath #(
  parameter int MAX_RADIX  = sre_pkg::DEF_MAX_RADIX,
  parameter int VALUE_BITS = sre_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [sre_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sre_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [sre_pkg::VALUE_W-1:0]     value,
  input  sre_pkg::cmd_t                   cmd,
  output sre_pkg::status_t                status,
  output logic                            strobe,
  output logic [sre_pkg::CHAR_W-1:0]      character,
  output logic                            final_char
);
  import sre_pkg::*;

  localparam int DIG_W  = $clog2(MAX_RADIX);
  localparam int NDIG   = VALUE_BITS;
  localparam int LEN_W  = $clog2(NDIG + 1);
  localparam int IDX_W  = $clog2(NDIG);
  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int WIDE_W = RADIX_W + 1;

  logic [RADIX_W-1:0]    radix_size;
  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_size   <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_RADIX_SIZE:   radix_size   <= cfg_wdata[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_wdata;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [2*CFG_DATA_W-1:0] sym_all;
  logic [CHAR_W-1:0]       sym [SYM_COUNT];
  logic                    alpha_ok;

  assign sym_all = {symbols_high, symbols_low};

  always_comb begin
    for (int i = 0; i < SYM_COUNT; i++) begin
      sym[i] = sym_all[CHAR_W*i +: CHAR_W];
    end
  end

  // radix range check, no sign character and pairwise compare over the symbols in use
  always_comb begin
    alpha_ok = (radix_size >= RADIX_W'(2)) && (radix_size <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < SYM_COUNT; i++) begin
      if ((RADIX_W'(i) < radix_size) && ((sym[i] == CH_MINUS) || (sym[i] == CH_PLUS))) begin
        alpha_ok = 1'b0;
      end
      for (int j = i + 1; j < SYM_COUNT; j++) begin
        if ((RADIX_W'(j) < radix_size) && (sym[i] == sym[j])) alpha_ok = 1'b0;
      end
    end
  end

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [CNT_W-1:0]      bitcnt;
  logic [DIG_W-1:0]      dig [NDIG];
  logic [LEN_W-1:0]      len;
  logic [IDX_W-1:0]      idx;

  logic [NDIG-1:0]       gen;
  logic [NDIG-1:0]       prop;
  logic [NDIG:0]         sum;
  logic [NDIG:0]         carry;
  logic [WIDE_W-1:0]     twice [NDIG];
  logic [WIDE_W-1:0]     corr [NDIG];
  logic [DIG_W-1:0]      dig_next [NDIG];
  logic [LEN_W-1:0]      len_next;
  logic [IDX_W-1:0]      idx_next;

  assign raw = value[VALUE_BITS-1:0];

  // digits = 2 * digits + bit, carries between digits resolved as one add:
  // a digit generates when 2d >= r and propagates when 2d + 1 == r
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      twice[i] = WIDE_W'({dig[i], 1'b0});
      gen[i]   = twice[i] >= WIDE_W'(radix_size);
      prop[i]  = (twice[i] + WIDE_W'(1)) == WIDE_W'(radix_size);
    end
    sum   = {1'b0, gen | prop} + {1'b0, gen} + (NDIG + 1)'(mag[VALUE_BITS-1]);
    carry = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};
    for (int i = 0; i < NDIG; i++) begin
      corr[i] = twice[i] + WIDE_W'(carry[i])
              - (carry[i+1] ? WIDE_W'(radix_size) : WIDE_W'(0));
      dig_next[i] = corr[i][DIG_W-1:0];
    end
  end

  // length grows when a carry reaches the first unused digit
  assign len_next = len + LEN_W'(carry[len]);
  assign idx_next = IDX_W'(len_next - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // two's complement negate in VALUE_BITS bits gives the true magnitude,
      // the most negative value included
      mag    <= raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
      neg    <= raw[VALUE_BITS-1];
      bitcnt <= CNT_W'(VALUE_BITS - 1);
      len    <= LEN_W'(1);
      for (int i = 0; i < NDIG; i++) begin
        dig[i] <= '0;
      end
    end else if (cmd.shift) begin
      mag    <= {mag[VALUE_BITS-2:0], 1'b0};
      bitcnt <= bitcnt - CNT_W'(1);
      len    <= len_next;
      idx    <= idx_next;
      for (int i = 0; i < NDIG; i++) begin
        dig[i] <= dig_next[i];
      end
    end else if (cmd.emit_digit) begin
      idx <= idx - IDX_W'(1);
    end
  end

  assign status.alpha_ok   = alpha_ok;
  assign status.neg        = neg;
  assign status.conv_last  = (bitcnt == '0);
  assign status.digit_last = (idx == '0);

  logic [CHAR_W-1:0] digit_char;

  assign digit_char = sym[SYM_IDX_W'(dig[idx])];

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      final_char <= 1'b0;
    end else begin
      strobe     <= cmd.emit_sign || cmd.emit_digit;
      final_char <= cmd.emit_digit && (idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    character <= cmd.emit_sign ? CH_MINUS : digit_char;
  end

endmodule

### src/signed_radix_digit_emitter_unit.sv
// ---------------------------------------------------------------------------
// signed_radix_digit_emitter_unit
// formats a signed integer as text in a configurable radix and alphabet
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   config   | cfg_wen                 | cfg_index, cfg_wdata
//   input    | start & !busy           | value
//   result   | strobe (no backpressure)| character, final_char
//
// after a word is taken, the magnitude runs bit-serially through the radix
// digit accumulator, then a '-' is emitted if the value is negative, then
// the digits; each character is registered and shows in the cycle after its
// emit step. a bad alphabet takes the word and emits nothing.
// synchronous reset clears the sequencer, the strobe and the config.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_radix_digit_emitter_unit #(
  parameter int MAX_RADIX  = sre_pkg::DEF_MAX_RADIX,
  parameter int VALUE_BITS = sre_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [sre_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sre_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            start,
  input  logic [sre_pkg::VALUE_W-1:0]     value,
  output logic                            busy,
  output logic                            strobe,
  output logic [sre_pkg::CHAR_W-1:0]      character,
  output logic                            final_char
);
  import sre_pkg::*;

  cmd_t    cmd;
  status_t status;

  sre_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sre_datapath #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .strobe     (strobe),
    .character  (character),
    .final_char (final_char)
  );

endmodule

### src/sre_checker.sv
// ---------------------------------------------------------------------------
// sre_checker
// port-level checks on the emitter's word and character timing
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signed_radix_digit_emitter_unit_defines.svh"

module sre_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic final_char
);

  // characters only come out of a running conversion
  `SRE_ASSERT_SAME(a_strobe_after_busy, clk, rst, strobe, $past(busy), "character without a word in work")

  // a word just taken cannot show a character yet
  `SRE_ASSERT_NEXT(a_no_char_on_accept, clk, rst, start && !busy, !strobe, "character right after accept")

  // only a final character may end the busy period
  `SRE_ASSERT_SAME(a_mid_char_busy, clk, rst, strobe && !final_char, busy, "busy dropped mid string")

  // the final flag closes the stream
  `SRE_ASSERT_NEXT(a_gap_after_final, clk, rst, strobe && final_char, !strobe, "character after final")

endmodule

bind signed_radix_digit_emitter_unit sre_checker u_sre_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .final_char (final_char)
);
